FILE: hw/rtl/tms_pkg.sv
// Shared types and constants of the Turing machine step engine.
// No dependencies; the top level takes names from here by scope, tms_ram does not.
`timescale 1ns / 1ps

package tms_pkg;

	localparam int STATE_COUNT  = 64;
	localparam int STATE_W      = 6;
	localparam int TAPE_CELLS   = 4096;
	localparam int TAPE_AW      = 12;
	localparam int ALPHABET_MAX = 8;
	localparam int SYM_W        = 3;
	localparam int SLOT_COUNT   = STATE_COUNT * ALPHABET_MAX;
	localparam int SLOT_W       = STATE_W + SYM_W;
	localparam int CHAR_W       = 8;
	localparam int MOVE_W       = 8;
	localparam int ALPHA_W      = ALPHABET_MAX * CHAR_W;
	localparam int SIZE_W       = 4;
	localparam int CFG_IDX_W    = 1;

	localparam logic [STATE_W-1:0] ST_ACCEPT     = 6'd0;
	localparam logic [STATE_W-1:0] ST_DECLINE    = 6'd1;
	localparam logic [STATE_W-1:0] ST_ERROR      = 6'd2;
	localparam logic [STATE_W-1:0] ST_FIRST_USER = 6'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_CHARS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE  = 1'd1;

	typedef enum logic [1:0] {
		MODE_LOAD_TRANS = 2'd0,
		MODE_LOAD_CELL  = 2'd1,
		MODE_STEP       = 2'd2,
		MODE_RESTART    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_TAPE,
		FSM_TAB,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		mode_t                    mode;
		logic [STATE_W-1:0]       entry_state;
		logic [SYM_W-1:0]         entry_symbol;
		logic [CHAR_W-1:0]        entry_out_char;
		logic signed [MOVE_W-1:0] entry_move;
		logic [STATE_W-1:0]       entry_next;
		logic [TAPE_AW-1:0]       cell_addr;
		logic [CHAR_W-1:0]        cell_char;
	} in_item_t;

	typedef struct packed {
		logic [STATE_W-1:0] cur_state;
		logic [TAPE_AW-1:0] head_pos;
		logic [CHAR_W-1:0]  written_char;
		logic               halted;
	} out_item_t;

	typedef struct packed {
		logic              written;
		logic [CHAR_W-1:0] ch;
	} tape_word_t;

	typedef struct packed {
		logic                     valid;
		logic [CHAR_W-1:0]        out_char;
		logic signed [MOVE_W-1:0] move;
		logic [STATE_W-1:0]       nxt;
	} trans_word_t;

	localparam int TAPE_WORD_W  = $bits(tape_word_t);
	localparam int TRANS_WORD_W = $bits(trans_word_t);

endpackage

FILE: hw/rtl/tms_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps

module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/turing_machine_step.sv
// Top level of the Turing machine step engine: control, registers, tape and table.
// Depends on tms_pkg and tms_ram.
`timescale 1ns / 1ps

// After reset the block clears the tape and transition memories and takes no
// transaction in that time; configuration writes are accepted throughout. A
// step reads the tape cell under the head, then reads the transition entry
// and writes the cell back, then registers the result while the next
// transaction may be accepted; a cell symbol outside the alphabet skips the
// entry read. Loads, restarts and steps of a halted machine go straight to
// the result. The two memory reads of a step are dependent. Results wait in
// an output register, so a stalled output blocks the input only once a
// second result is ready.
module turing_machine_step (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  tms_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tms_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [tms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tms_pkg::ALPHA_W-1:0]        cfg_data
);

	tms_pkg::fsm_t fsm_q, fsm_d;

	logic [tms_pkg::ALPHA_W-1:0] alpha_q;
	logic [tms_pkg::SIZE_W-1:0]  size_q;
	logic [tms_pkg::STATE_W-1:0] state_q;
	logic [tms_pkg::TAPE_AW-1:0] head_q;
	logic [tms_pkg::CHAR_W-1:0]  written_q;
	logic                        clearing_q;
	logic [tms_pkg::TAPE_AW-1:0] clr_addr_q;
	logic                        out_valid_q;
	tms_pkg::out_item_t          out_data_q;

	logic accept, out_free, halted, step_go;
	logic [tms_pkg::SIZE_W-1:0] eff_size;
	logic [tms_pkg::CHAR_W-1:0] cur_ch;
	logic [tms_pkg::SYM_W-1:0]  sym_idx;
	logic                       sym_found;
	logic signed [tms_pkg::TAPE_AW+1:0] target;
	logic                       trans_ok;

	logic                            tape_we;
	logic [tms_pkg::TAPE_AW-1:0]     tape_waddr;
	tms_pkg::tape_word_t             tape_wdata, tape_rdata;
	logic                            tab_we;
	logic [tms_pkg::SLOT_W-1:0]      tab_waddr, tab_raddr;
	tms_pkg::trans_word_t            tab_wdata, tab_rdata;

	tms_ram #(
		.WIDTH(tms_pkg::TAPE_WORD_W),
		.DEPTH(tms_pkg::TAPE_CELLS)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.raddr(head_q),
		.rdata(tape_rdata)
	);

	tms_ram #(
		.WIDTH(tms_pkg::TRANS_WORD_W),
		.DEPTH(tms_pkg::SLOT_COUNT)
	) u_table (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata(tab_wdata),
		.raddr(tab_raddr),
		.rdata(tab_rdata)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign halted   = (state_q <= tms_pkg::ST_ERROR);
	assign step_go  = (in_data.mode == tms_pkg::MODE_STEP) && !halted;

	always_comb begin
		if (size_q == '0) begin
			eff_size = tms_pkg::SIZE_W'(1);
		end else if (size_q > tms_pkg::SIZE_W'(tms_pkg::ALPHABET_MAX)) begin
			eff_size = tms_pkg::SIZE_W'(tms_pkg::ALPHABET_MAX);
		end else begin
			eff_size = size_q;
		end
	end

	assign cur_ch = tape_rdata.written ? tape_rdata.ch : alpha_q[tms_pkg::CHAR_W-1:0];

	always_comb begin
		sym_found = 1'b0;
		sym_idx   = '0;
		for (int i = 0; i < tms_pkg::ALPHABET_MAX; i++) begin
			if (!sym_found && (tms_pkg::SIZE_W'(i) < eff_size) &&
			    (alpha_q[i*tms_pkg::CHAR_W +: tms_pkg::CHAR_W] == cur_ch)) begin
				sym_found = 1'b1;
				sym_idx   = tms_pkg::SYM_W'(i);
			end
		end
	end

	assign tab_raddr = {state_q, sym_idx};

	assign target = $signed({2'b00, head_q}) +
		{{(tms_pkg::TAPE_AW + 2 - tms_pkg::MOVE_W){tab_rdata.move[tms_pkg::MOVE_W-1]}},
		 tab_rdata.move};
	assign trans_ok = tab_rdata.valid && (target[tms_pkg::TAPE_AW+1:tms_pkg::TAPE_AW] == 2'b00);

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			tms_pkg::FSM_IDLE: begin
				if (accept) begin
					fsm_d = step_go ? tms_pkg::FSM_TAPE : tms_pkg::FSM_OUT;
				end
			end
			tms_pkg::FSM_TAPE: begin
				fsm_d = sym_found ? tms_pkg::FSM_TAB : tms_pkg::FSM_OUT;
			end
			tms_pkg::FSM_TAB: begin
				fsm_d = tms_pkg::FSM_OUT;
			end
			tms_pkg::FSM_OUT: begin
				if (accept) begin
					fsm_d = step_go ? tms_pkg::FSM_TAPE : tms_pkg::FSM_OUT;
				end else if (out_free) begin
					fsm_d = tms_pkg::FSM_IDLE;
				end
			end
			default: fsm_d = tms_pkg::FSM_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		in_stall   = 1'b1;
		tape_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = '0;
		tab_we     = 1'b0;
		tab_waddr  = {in_data.entry_state, in_data.entry_symbol};
		tab_wdata  = '0;
		case (fsm_q)
			tms_pkg::FSM_IDLE: in_stall = clearing_q;
			tms_pkg::FSM_OUT:  in_stall = clearing_q || !out_free;
			tms_pkg::FSM_TAB: begin
				if (trans_ok) begin
					tape_we    = 1'b1;
					tape_wdata = '{written: 1'b1, ch: tab_rdata.out_char};
				end
			end
			default: in_stall = 1'b1;
		endcase
		if (clearing_q) begin
			tape_we    = 1'b1;
			tape_waddr = clr_addr_q;
			tape_wdata = '0;
			tab_we     = 1'b1;
			tab_waddr  = clr_addr_q[tms_pkg::SLOT_W-1:0];
			tab_wdata  = '0;
		end else if (accept) begin
			if (in_data.mode == tms_pkg::MODE_LOAD_TRANS) begin
				tab_we    = 1'b1;
				tab_wdata = '{valid: 1'b1, out_char: in_data.entry_out_char,
				              move: in_data.entry_move, nxt: in_data.entry_next};
			end
			if (in_data.mode == tms_pkg::MODE_LOAD_CELL) begin
				tape_we    = 1'b1;
				tape_waddr = in_data.cell_addr;
				tape_wdata = '{written: 1'b1, ch: in_data.cell_char};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= tms_pkg::FSM_IDLE;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			fsm_q <= fsm_d;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + tms_pkg::TAPE_AW'(1);
				if (clr_addr_q == tms_pkg::TAPE_AW'(tms_pkg::TAPE_CELLS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			size_q  <= tms_pkg::SIZE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				tms_pkg::CFG_ALPHABET_CHARS: alpha_q <= cfg_data;
				tms_pkg::CFG_ALPHABET_SIZE:  size_q  <= cfg_data[tms_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tms_pkg::ST_FIRST_USER;
			head_q  <= '0;
		end else begin
			if (accept && (in_data.mode == tms_pkg::MODE_RESTART)) begin
				state_q <= tms_pkg::ST_FIRST_USER;
				head_q  <= '0;
			end
			if ((fsm_q == tms_pkg::FSM_TAPE) && !sym_found) begin
				state_q <= tms_pkg::ST_ERROR;
			end
			if (fsm_q == tms_pkg::FSM_TAB) begin
				if (trans_ok) begin
					state_q <= tab_rdata.nxt;
					head_q  <= target[tms_pkg::TAPE_AW-1:0];
				end else begin
					state_q <= tms_pkg::ST_ERROR;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			written_q <= '0;
		end else if ((fsm_q == tms_pkg::FSM_TAB) && trans_ok) begin
			written_q <= tab_rdata.out_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((fsm_q == tms_pkg::FSM_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((fsm_q == tms_pkg::FSM_OUT) && out_free) begin
			out_data_q <= '{cur_state: state_q, head_pos: head_q,
			               written_char: written_q, halted: halted};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
